>>> rtl/lfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
// Holds parse phases, status and opcode codes, register indexes and reset values.
// No dependencies.
package lfp_pkg;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_LEN_HI   = 8'b0000_0010,
      PH_LEN_LO   = 8'b0000_0100,
      PH_PAYLOAD  = 8'b0000_1000,
      PH_CRC_HI   = 8'b0001_0000,
      PH_CRC_LO   = 8'b0010_0000,
      PH_END      = 8'b0100_0000,
      PH_COMPLETE = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TIMEOUT   = 3'd1,
      ST_TOO_BIG   = 3'd2,
      ST_BAD_END   = 3'd3,
      ST_BAD_STATE = 3'd4
   } status_type;

   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] REG_START_BYTE    = 2'd0;
   localparam logic [1:0] REG_END_BYTE      = 2'd1;
   localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd2;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

   localparam logic [7:0]  START_BYTE_RESET    = 8'd126;
   localparam logic [7:0]  END_BYTE_RESET      = 8'd127;
   localparam logic [10:0] MAX_PAYLOAD_RESET   = 11'd1024;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd500;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [10:0] max_payload;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        frame_done;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [9:0]  payload_index;
      logic [10:0] frame_length;
      logic [15:0] frame_crc;
   } rsp_type;

endpackage

>>> rtl/lfp_core.sv
// Parser state machine: holds the frame state and works out one result per item.
// Depends on lfp_pkg for phases, codes and the configuration and result structs.
module lfp_core #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [1:0]      opcode,
   input  logic [7:0]      data_byte,
   input  lfp_pkg::cfg_type cfg,
   output lfp_pkg::rsp_type result
);

   localparam logic [15:0] PayloadCap = 16'(MAX_PAYLOAD);

   lfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [10:0] length_ff, length_in;
   logic [10:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] ticks_ff, ticks_in;

   lfp_pkg::status_type status;
   logic        go_idle;
   logic        pay_valid;
   logic [15:0] full_len;
   logic [15:0] limit;
   logic [10:0] count_inc;

   always_comb begin
      // The effective limit is the smaller of the register and the build-time cap.
      limit = ({5'd0, cfg.max_payload} > PayloadCap) ? PayloadCap : {5'd0, cfg.max_payload};
      full_len  = {len_hi_ff, data_byte};
      count_inc = count_ff + 11'd1;

      phase_in  = phase_ff;
      len_hi_in = len_hi_ff;
      length_in = length_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      ticks_in  = ticks_ff;
      status    = lfp_pkg::ST_OK;
      go_idle   = 1'b0;
      pay_valid = 1'b0;

      case (opcode)
         lfp_pkg::OP_BYTE: begin
            if (phase_ff != lfp_pkg::PH_IDLE && ticks_ff >= cfg.timeout_ticks) begin
               go_idle = 1'b1;
               status  = lfp_pkg::ST_TIMEOUT;
            end else begin
               ticks_in = '0;
               unique case (phase_ff)
                  lfp_pkg::PH_IDLE: begin
                     if (data_byte == cfg.start_byte) begin
                        phase_in = lfp_pkg::PH_LEN_HI;
                        count_in = '0;
                     end
                  end
                  lfp_pkg::PH_LEN_HI: begin
                     len_hi_in = data_byte;
                     phase_in  = lfp_pkg::PH_LEN_LO;
                  end
                  lfp_pkg::PH_LEN_LO: begin
                     if (full_len > limit) begin
                        go_idle = 1'b1;
                        status  = lfp_pkg::ST_TOO_BIG;
                     end else begin
                        // The limit never exceeds 2047, so an accepted length fits 11 bits.
                        length_in = full_len[10:0];
                        count_in  = '0;
                        phase_in  = (full_len == 16'd0) ? lfp_pkg::PH_CRC_HI
                                                        : lfp_pkg::PH_PAYLOAD;
                     end
                  end
                  lfp_pkg::PH_PAYLOAD: begin
                     pay_valid = 1'b1;
                     count_in  = count_inc;
                     if (count_inc >= length_ff) begin
                        phase_in = lfp_pkg::PH_CRC_HI;
                     end
                  end
                  lfp_pkg::PH_CRC_HI: begin
                     crc_in   = {data_byte, 8'd0};
                     phase_in = lfp_pkg::PH_CRC_LO;
                  end
                  lfp_pkg::PH_CRC_LO: begin
                     crc_in   = {crc_ff[15:8], data_byte};
                     phase_in = lfp_pkg::PH_END;
                  end
                  lfp_pkg::PH_END: begin
                     if (data_byte == cfg.end_byte) begin
                        phase_in = lfp_pkg::PH_COMPLETE;
                     end else begin
                        go_idle = 1'b1;
                        status  = lfp_pkg::ST_BAD_END;
                     end
                  end
                  default: begin
                     go_idle = 1'b1;
                     status  = lfp_pkg::ST_BAD_STATE;
                  end
               endcase
            end
         end
         lfp_pkg::OP_TICK: begin
            if (ticks_ff != 16'hFFFF) begin
               ticks_in = ticks_ff + 16'd1;
            end
         end
         lfp_pkg::OP_CLEAR: begin
            go_idle = 1'b1;
         end
         default: ;
      endcase

      if (go_idle) begin
         phase_in  = lfp_pkg::PH_IDLE;
         len_hi_in = '0;
         length_in = '0;
         count_in  = '0;
         crc_in    = '0;
         ticks_in  = '0;
      end

      result.status        = status;
      result.frame_done    = (phase_in == lfp_pkg::PH_COMPLETE);
      result.payload_valid = pay_valid;
      result.payload_byte  = pay_valid ? data_byte : 8'd0;
      result.payload_index = pay_valid ? count_ff[9:0] : 10'd0;
      result.frame_length  = (phase_in == lfp_pkg::PH_PAYLOAD || phase_in == lfp_pkg::PH_CRC_HI ||
                              phase_in == lfp_pkg::PH_CRC_LO || phase_in == lfp_pkg::PH_END ||
                              phase_in == lfp_pkg::PH_COMPLETE) ? length_in : 11'd0;
      result.frame_crc     = (phase_in == lfp_pkg::PH_END || phase_in == lfp_pkg::PH_COMPLETE)
                             ? crc_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lfp_pkg::PH_IDLE;
         len_hi_ff <= '0;
         length_ff <= '0;
         count_ff  <= '0;
         crc_ff    <= '0;
         ticks_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         len_hi_ff <= len_hi_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         ticks_ff  <= ticks_in;
      end
   end

endmodule

>>> rtl/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser: register port, parser core and
// a two-entry result buffer. Depends on lfp_pkg and lfp_core.
//
// Usage: each item on the req_ channel is a received byte, a time tick or a
// clear command. Every accepted item yields exactly one item on the rsp_
// channel, carrying status, frame state and any payload byte with its index.
// Payload bytes are streamed out as they arrive and are never buffered.
// Each result is registered in the output register, or in the skid register
// if the receiver stalls; one item per cycle is taken while req_stall is low.
// Results pass through an output register backed by a skid register, so an
// item is still taken while one result waits; req_stall rises only once both
// are full and falls in the cycle after the receiver takes a result.
// Reset (synchronous, active high) returns the parser to idle, empties the
// result buffer and loads the register defaults. Registers must be written
// over the csr_ port only while idle (not enforced); read back at any time.
module length_prefixed_frame_parser #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_frame_done,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic [9:0]  rsp_payload_index,
   output logic [10:0] rsp_frame_length,
   output logic [15:0] rsp_frame_crc,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lfp_pkg::cfg_type cfg_ff, cfg_in;
   lfp_pkg::rsp_type core_rsp;
   lfp_pkg::rsp_type out_ff, out_in;
   lfp_pkg::rsp_type skid_ff, skid_in;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic in_accept;
   logic out_take;
   logic csr_write;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            lfp_pkg::REG_START_BYTE:    cfg_in.start_byte    = csr_pwdata[7:0];
            lfp_pkg::REG_END_BYTE:      cfg_in.end_byte      = csr_pwdata[7:0];
            lfp_pkg::REG_MAX_PAYLOAD:   cfg_in.max_payload   = csr_pwdata[10:0];
            lfp_pkg::REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         lfp_pkg::REG_START_BYTE:    csr_prdata = {24'd0, cfg_ff.start_byte};
         lfp_pkg::REG_END_BYTE:      csr_prdata = {24'd0, cfg_ff.end_byte};
         lfp_pkg::REG_MAX_PAYLOAD:   csr_prdata = {21'd0, cfg_ff.max_payload};
         lfp_pkg::REG_TIMEOUT_TICKS: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= lfp_pkg::START_BYTE_RESET;
         cfg_ff.end_byte      <= lfp_pkg::END_BYTE_RESET;
         cfg_ff.max_payload   <= lfp_pkg::MAX_PAYLOAD_RESET;
         cfg_ff.timeout_ticks <= lfp_pkg::TIMEOUT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Parser core.
   assign req_stall = skid_valid_ff;
   assign in_accept = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   lfp_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (in_accept),
      .opcode    (req_opcode),
      .data_byte (req_data_byte),
      .cfg       (cfg_ff),
      .result    (core_rsp)
   );

   // Result buffer: the skid register only fills when a new item arrives while
   // the output register is held by a stalled receiver.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = core_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = core_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_frame_done    = out_ff.frame_done;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_index = out_ff.payload_index;
   assign rsp_frame_length  = out_ff.frame_length;
   assign rsp_frame_crc     = out_ff.frame_crc;

endmodule

>>> sim/tb.sv
// Testbench for length_prefixed_frame_parser: directed frames, then random frames and noise
// under several register settings, each result checked against a built-in parser model.
// Depends on lfp_pkg and the length_prefixed_frame_parser RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PARSER_MAX = 1024;
   localparam int CYCLE_LIMIT = 400_000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Parser model and store of expected results.
   class frame_scoreboard;
      logic [7:0]          start_val;
      logic [7:0]          end_val;
      logic [10:0]         max_len;
      logic [15:0]         tick_limit;
      lfp_pkg::phase_type  phase;
      logic [15:0]         length;
      logic [10:0]         count;
      logic [15:0]         crc;
      logic [15:0]         ticks;
      lfp_pkg::rsp_type    calc;
      lfp_pkg::rsp_type    expected_q[$];
      int                  errors;

      function new();
         start_val = lfp_pkg::START_BYTE_RESET;
         end_val = lfp_pkg::END_BYTE_RESET;
         max_len = lfp_pkg::MAX_PAYLOAD_RESET;
         tick_limit = lfp_pkg::TIMEOUT_TICKS_RESET;
         errors = 0;
         go_idle();
      endfunction

      function void go_idle();
         phase = lfp_pkg::PH_IDLE;
         length = '0;
         count = '0;
         crc = '0;
         ticks = '0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            lfp_pkg::REG_START_BYTE:    start_val = value[7:0];
            lfp_pkg::REG_END_BYTE:      end_val = value[7:0];
            lfp_pkg::REG_MAX_PAYLOAD:   max_len = value[10:0];
            lfp_pkg::REG_TIMEOUT_TICKS: tick_limit = value[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [1:0] idx);
         case (idx)
            lfp_pkg::REG_START_BYTE:  return {24'd0, start_val};
            lfp_pkg::REG_END_BYTE:    return {24'd0, end_val};
            lfp_pkg::REG_MAX_PAYLOAD: return {21'd0, max_len};
            default:                  return {16'd0, tick_limit};
         endcase
      endfunction

      function int length_cap();
         return (int'(max_len) > PARSER_MAX) ? PARSER_MAX : int'(max_len);
      endfunction

      function void take_byte(logic [7:0] b);
         // A byte that arrives late in a frame is dropped and ends the frame.
         if (phase != lfp_pkg::PH_IDLE && ticks >= tick_limit) begin
            go_idle();
            calc.status = lfp_pkg::ST_TIMEOUT;
            return;
         end
         ticks = '0;
         case (phase)
            lfp_pkg::PH_IDLE: begin
               if (b == start_val) begin
                  phase = lfp_pkg::PH_LEN_HI;
                  count = '0;
               end
            end
            lfp_pkg::PH_LEN_HI: begin
               length = {b, 8'h00};
               phase = lfp_pkg::PH_LEN_LO;
            end
            lfp_pkg::PH_LEN_LO: begin
               length = length | {8'h00, b};
               if (int'(length) > length_cap()) begin
                  go_idle();
                  calc.status = lfp_pkg::ST_TOO_BIG;
               end else begin
                  count = '0;
                  phase = (length == 16'd0) ? lfp_pkg::PH_CRC_HI : lfp_pkg::PH_PAYLOAD;
               end
            end
            lfp_pkg::PH_PAYLOAD: begin
               calc.payload_valid = 1'b1;
               calc.payload_byte = b;
               calc.payload_index = count[9:0];
               count = count + 11'd1;
               if ({5'd0, count} >= length) phase = lfp_pkg::PH_CRC_HI;
            end
            lfp_pkg::PH_CRC_HI: begin
               crc = {b, 8'h00};
               phase = lfp_pkg::PH_CRC_LO;
            end
            lfp_pkg::PH_CRC_LO: begin
               crc = crc | {8'h00, b};
               phase = lfp_pkg::PH_END;
            end
            lfp_pkg::PH_END: begin
               if (b == end_val) begin
                  phase = lfp_pkg::PH_COMPLETE;
               end else begin
                  go_idle();
                  calc.status = lfp_pkg::ST_BAD_END;
               end
            end
            default: begin
               go_idle();
               calc.status = lfp_pkg::ST_BAD_STATE;
            end
         endcase
      endfunction

      function void note_item(logic [1:0] op, logic [7:0] b);
         calc = '0;
         calc.status = lfp_pkg::ST_OK;
         case (op)
            lfp_pkg::OP_BYTE:  take_byte(b);
            lfp_pkg::OP_TICK:  if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
            lfp_pkg::OP_CLEAR: go_idle();
            default: ;
         endcase
         if (phase == lfp_pkg::PH_PAYLOAD || phase == lfp_pkg::PH_CRC_HI ||
             phase == lfp_pkg::PH_CRC_LO || phase == lfp_pkg::PH_END ||
             phase == lfp_pkg::PH_COMPLETE)
            calc.frame_length = length[10:0];
         if (phase == lfp_pkg::PH_END || phase == lfp_pkg::PH_COMPLETE) calc.frame_crc = crc;
         calc.frame_done = (phase == lfp_pkg::PH_COMPLETE);
         expected_q.push_back(calc);
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void field_check(string what, int unsigned want, int unsigned got);
         if (want != got)
            note_error($sformatf("mismatch in %s: expected %0d, got %0d", what, want, got));
      endfunction

      function void check_result(lfp_pkg::rsp_type got);
         lfp_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            note_error("result item arrived with nothing expected");
            return;
         end
         want = expected_q.pop_front();
         field_check("status", want.status, got.status);
         field_check("frame_done", want.frame_done, got.frame_done);
         field_check("payload_valid", want.payload_valid, got.payload_valid);
         field_check("payload_byte", want.payload_byte, got.payload_byte);
         field_check("payload_index", want.payload_index, got.payload_index);
         field_check("frame_length", want.frame_length, got.frame_length);
         field_check("frame_crc", want.frame_crc, got.frame_crc);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic        rsp_frame_done;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_byte;
   logic [9:0]  rsp_payload_index;
   logic [10:0] rsp_frame_length;
   logic [15:0] rsp_frame_crc;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_scoreboard  sb;
   lfp_pkg::rsp_type seen_rsp;
   int               cycle_count = 0;
   int               items_sent;
   bit               calm;
   int               stall_left = 0;
   bit               stall_phase = 1'b0;

   length_prefixed_frame_parser #(.MAX_PAYLOAD(PARSER_MAX)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_frame_done(rsp_frame_done),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_payload_index(rsp_payload_index),
      .rsp_frame_length(rsp_frame_length),
      .rsp_frame_crc(rsp_frame_crc),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.status = lfp_pkg::status_type'(rsp_status);
            seen_rsp.frame_done = rsp_frame_done;
            seen_rsp.payload_valid = rsp_payload_valid;
            seen_rsp.payload_byte = rsp_payload_byte;
            seen_rsp.payload_index = rsp_payload_index;
            seen_rsp.frame_length = rsp_frame_length;
            seen_rsp.frame_crc = rsp_frame_crc;
            sb.check_result(seen_rsp);
         end
         if (req_valid && !req_stall) sb.note_item(req_opcode, req_data_byte);
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // The receiver alternates between stretches that never stall and stretches that do.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
         end else if (stall_phase && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = gap_len();
         end else begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(0, 5);
         end
         if ($urandom_range(0, 199) == 0) stall_phase = !stall_phase;
      end
   end

   task automatic drive_item(logic [1:0] op, logic [7:0] b);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 45) gap = gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Sends n bytes, most significant byte of the vector first.
   task automatic send_bytes(logic [63:0] seq, int n);
      for (int i = n - 1; i >= 0; i--) drive_item(lfp_pkg::OP_BYTE, seq[8*i +: 8]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.field_check($sformatf("register %0d readback", idx), sb.reg_value(idx), csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(logic [7:0] s, logic [7:0] e, logic [10:0] m, logic [15:0] t);
      settle();
      write_reg(lfp_pkg::REG_START_BYTE, {24'd0, s});
      write_reg(lfp_pkg::REG_END_BYTE, {24'd0, e});
      write_reg(lfp_pkg::REG_MAX_PAYLOAD, {21'd0, m});
      write_reg(lfp_pkg::REG_TIMEOUT_TICKS, {16'd0, t});
   endtask

   // Now and then idle time falls inside a frame, sometimes enough to time it out.
   task automatic maybe_ticks();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         repeat ($urandom_range(1, 3)) drive_item(lfp_pkg::OP_TICK, 8'($urandom));
      end else if (r < 8 && sb.tick_limit <= 16'd40) begin
         repeat (sb.tick_limit) drive_item(lfp_pkg::OP_TICK, 8'($urandom));
      end
   endtask

   task automatic send_frame(int len);
      logic [15:0] len16;
      logic [7:0]  last;
      int          r;
      len16 = len[15:0];
      drive_item(lfp_pkg::OP_BYTE, sb.start_val);
      maybe_ticks();
      drive_item(lfp_pkg::OP_BYTE, len16[15:8]);
      drive_item(lfp_pkg::OP_BYTE, len16[7:0]);
      if (len > sb.length_cap()) return;
      for (int i = 0; i < len; i++) begin
         maybe_ticks();
         if ($urandom_range(0, 299) == 0) begin
            drive_item(lfp_pkg::OP_CLEAR, 8'($urandom));
            return;
         end
         drive_item(lfp_pkg::OP_BYTE, 8'($urandom));
      end
      drive_item(lfp_pkg::OP_BYTE, 8'($urandom));
      maybe_ticks();
      drive_item(lfp_pkg::OP_BYTE, 8'($urandom));
      last = sb.end_val;
      if ($urandom_range(0, 99) < 6) last = last ^ 8'($urandom_range(1, 255));
      drive_item(lfp_pkg::OP_BYTE, last);
      // A finished frame must be cleared; any further byte is an error.
      r = $urandom_range(0, 99);
      if (r < 75) drive_item(lfp_pkg::OP_CLEAR, 8'($urandom));
      else if (r < 90) drive_item(lfp_pkg::OP_BYTE, 8'($urandom));
   endtask

   task automatic random_frame();
      int cap;
      int r;
      int len;
      cap = sb.length_cap();
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(0, (cap < 12) ? cap : 12);
      else if (r < 92) len = $urandom_range(0, (cap < 80) ? cap : 80);
      else if (r < 97) len = $urandom_range(0, 1) ? cap + 1 : $urandom_range(cap + 1, 65535);
      else len = (cap <= 100) ? cap : $urandom_range(0, 8);
      calm = ($urandom_range(0, 3) == 0);
      send_frame(len);
      calm = 1'b0;
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4)) drive_item(2'($urandom_range(0, 3)), 8'($urandom));
   endtask

   task automatic random_run(int amount);
      int target;
      target = items_sent + amount;
      while (items_sent < target) begin
         if ($urandom_range(0, 99) < 85) random_frame();
         else send_noise();
      end
   endtask

   initial begin
      logic [7:0] same;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = lfp_pkg::OP_BYTE;
      req_data_byte = 8'd0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 4'd0;
      csr_pwdata = 32'd0;
      calm = 1'b0;
      items_sent = 0;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the register defaults.
      drive_item(OP_UNUSED, 8'hFF);
      drive_item(lfp_pkg::OP_BYTE, 8'h00);
      drive_item(lfp_pkg::OP_TICK, 8'hA5);
      send_bytes(64'h7E_0000_FF00_7F, 6);
      drive_item(lfp_pkg::OP_BYTE, 8'h7E);
      send_bytes(64'h7E_0001_FF_00FF_00, 7);
      send_bytes(64'h7E_FFFF, 3);
      send_bytes(64'h7E_0401, 3);
      send_bytes(64'h7E_0002_55, 4);
      drive_item(lfp_pkg::OP_CLEAR, 8'h00);

      // Low extremes, with a plain timeout up front.
      apply_settings(8'h00, 8'hFF, 11'd0, 16'd1);
      drive_item(lfp_pkg::OP_BYTE, 8'h00);
      drive_item(lfp_pkg::OP_TICK, 8'h00);
      drive_item(lfp_pkg::OP_BYTE, 8'h00);
      random_run(130);

      // High extremes: the register above the build-time cap, and a frame just too long.
      apply_settings(8'hFF, 8'h00, 11'd2047, 16'd65535);
      send_frame(1025);
      random_run(130);

      apply_settings(8'($urandom), 8'($urandom), 11'd20, 16'd5);
      random_run(130);
      apply_settings(8'($urandom), 8'($urandom), 11'($urandom_range(0, 1024)),
                     16'($urandom_range(1, 40)));
      random_run(130);
      same = 8'($urandom);
      apply_settings(same, same, 11'd1023, 16'd3);
      random_run(130);
      apply_settings(8'($urandom), 8'($urandom), 11'($urandom_range(1, 64)),
                     16'($urandom_range(1, 65535)));
      random_run(130);

      settle();
      repeat (8) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
